// ===== rtl/timestamp_to_calendar_macros.svh =====
// Assertion macros shared by the timestamp to calendar block.
`ifndef TIMESTAMP_TO_CALENDAR_MACROS_SVH
`define TIMESTAMP_TO_CALENDAR_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define TTC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define TTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TTC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define TTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/ttc_pkg.sv =====
// Constants, pipeline item types and the month table of the timestamp to calendar block.
`default_nettype none
package ttc_pkg;

   // Calendar constants.
   localparam int SECS_PER_MIN    = 60;
   localparam int SECS_PER_HOUR   = 3600;
   localparam int SECS_PER_DAY    = 86400;
   localparam int DAYS_PER_YEAR   = 365;
   localparam int DAYS_PER_CYCLE  = 1461;
   localparam int YEARS_PER_CYCLE = 4;
   localparam int SECS_PER_YEAR   = DAYS_PER_YEAR * SECS_PER_DAY;
   localparam int MARCH_1900_SECS = 59 * SECS_PER_DAY;
   localparam int BASE_YEAR       = 1900;
   localparam int FIRST_WEEKDAY   = 1;
   localparam int DAYS_PER_WEEK   = 7;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int MS_DIVISOR      = ((1 << 29) / 125) + 1;

   // Index of January in the March-based month count, and the month number of March.
   localparam int JANUARY_INDEX   = 10;
   localparam int MARCH_NUMBER    = 3;
   // Day of year at which January starts, counted from 1 March.
   localparam int JANUARY_START   = 306;
   // Days from 1 January to the day before 1 March in a common year, plus one.
   localparam int MARCH_ORDINAL   = 60;

   // Biases added to the local seconds to count from 1 March 1900.
   localparam logic [31:0] EARLY_BIAS = 32'(SECS_PER_YEAR - MARCH_1900_SECS);
   localparam logic [31:0] LATE_BIAS  = 32'(-MARCH_1900_SECS);
   localparam logic [31:0] MARCH_1900 = 32'(MARCH_1900_SECS);

   // Reciprocals for the divisions by constants. Each quotient estimate is at most
   // one too low because the dividend stays below two to the power of the shift.
   localparam int DAY_SHIFT        = 7;
   localparam int DAY_DIV          = SECS_PER_DAY / (1 << DAY_SHIFT);
   localparam int DAY_RECIP_SHIFT  = 25;
   localparam int DAY_RECIP        = (1 << DAY_RECIP_SHIFT) / DAY_DIV;

   localparam int MS_SHIFT         = 3;
   localparam int MS_DIV           = MS_DIVISOR / (1 << MS_SHIFT);
   localparam int MS_RECIP_SHIFT   = 29;
   localparam int MS_RECIP         = (1 << MS_RECIP_SHIFT) / MS_DIV;

   localparam int CYCLE_RECIP_SHIFT = 16;
   localparam int CYCLE_RECIP       = (1 << CYCLE_RECIP_SHIFT) / DAYS_PER_CYCLE;

   localparam int HOUR_SHIFT        = 4;
   localparam int HOUR_DIV          = SECS_PER_HOUR / (1 << HOUR_SHIFT);
   localparam int HOUR_RECIP_SHIFT  = 13;
   localparam int HOUR_RECIP        = (1 << HOUR_RECIP_SHIFT) / HOUR_DIV;

   localparam int WEEK_RECIP_SHIFT  = 16;
   localparam int WEEK_RECIP        = (1 << WEEK_RECIP_SHIFT) / DAYS_PER_WEEK;

   localparam int YEAR_RECIP_SHIFT  = 11;
   localparam int YEAR_RECIP        = (1 << YEAR_RECIP_SHIFT) / DAYS_PER_YEAR;

   localparam int MIN_SHIFT         = 2;
   localparam int MIN_DIV           = SECS_PER_MIN / (1 << MIN_SHIFT);
   localparam int MIN_RECIP_SHIFT   = 10;
   localparam int MIN_RECIP         = (1 << MIN_RECIP_SHIFT) / MIN_DIV;

   // First day of each month, counted from 1 March.
   localparam logic [8:0] MARCH_MONTH_START [MONTHS_PER_YEAR] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };

   // Item leaving the day split: whole days, seconds of the day and milliseconds.
   typedef struct packed {
      logic        valid;
      logic        early;
      logic [15:0] days;
      logic [16:0] in_day;
      logic [15:0] day_local;
      logic [9:0]  ms;
   } ttc_day_type;

   // Item leaving the time split: position within the four-year cycle and the clock.
   typedef struct packed {
      logic        valid;
      logic        early;
      logic [5:0]  cycle;
      logic [1:0]  cycle_year;
      logic [8:0]  year_day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  ms;
      logic [2:0]  weekday;
   } ttc_time_type;

   // Finished result item.
   typedef struct packed {
      logic        valid;
      logic [10:0] calendar_year;
      logic [3:0]  month_number;
      logic [4:0]  day_of_month;
      logic [4:0]  hour_of_day;
      logic [5:0]  minute_of_hour;
      logic [5:0]  second_of_minute;
      logic [9:0]  milliseconds;
      logic [2:0]  weekday;
      logic [8:0]  ordinal_day;
   } ttc_result_type;

   // March-based month index of a day of the year.
   function automatic logic [3:0] march_month(input logic [8:0] year_day);
      logic [3:0] month_index;
      month_index = 4'(MONTHS_PER_YEAR - 1);
      for (int k = MONTHS_PER_YEAR - 1; k >= 1; k--) begin
         if (year_day < MARCH_MONTH_START[k]) begin
            month_index = 4'(k - 1);
         end
      end
      return month_index;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ttc_req_if.sv =====
// Input channel carrying one timestamp item.
`default_nettype none
interface ttc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] seconds_since_1900;
   logic [31:0] second_fraction;

   modport source (output valid, output seconds_since_1900, output second_fraction,
                   input ready);
   modport sink (input valid, input seconds_since_1900, input second_fraction,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/ttc_rsp_if.sv =====
// Result channel carrying one calendar item.
`default_nettype none
interface ttc_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] calendar_year;
   logic [3:0]  month_number;
   logic [4:0]  day_of_month;
   logic [4:0]  hour_of_day;
   logic [5:0]  minute_of_hour;
   logic [5:0]  second_of_minute;
   logic [9:0]  milliseconds;
   logic [2:0]  weekday;
   logic [8:0]  ordinal_day;

   modport source (output valid, output calendar_year, output month_number,
                   output day_of_month, output hour_of_day, output minute_of_hour,
                   output second_of_minute, output milliseconds, output weekday,
                   output ordinal_day, input ready);
   modport sink (input valid, input calendar_year, input month_number,
                 input day_of_month, input hour_of_day, input minute_of_hour,
                 input second_of_minute, input milliseconds, input weekday,
                 input ordinal_day, output ready);
endinterface
`default_nettype wire

// ===== rtl/timestamp_to_calendar.sv =====
// Throughput: one item per cycle while rsp_channel.ready is high; each division by
// a constant takes a multiply stage and a correction stage of the nine-stage elastic
// pipeline.
// Stages that are empty keep taking items while a finished item waits at the output.
// Reset is synchronous and active high: it empties the pipeline and sets the zone
// offset to zero. There is no clearing pass.
`default_nettype none
`include "timestamp_to_calendar_macros.svh"
module timestamp_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data,
   ttc_req_if.sink     req_channel,
   ttc_rsp_if.source   rsp_channel
);

   logic [16:0]             zone_offset_ff;
   ttc_pkg::ttc_day_type    day_item;
   ttc_pkg::ttc_time_type   time_item;
   ttc_pkg::ttc_result_type result_item;
   logic                    time_ready;
   logic                    date_ready;

   // Zone offset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_offset_ff <= 17'd0;
      end else if (csr_write_enable) begin
         zone_offset_ff <= csr_write_data;
      end
   end

   // Pipeline sections.
   ttc_day_split u_day_split (
      .clock       (clock),
      .reset       (reset),
      .zone_offset (zone_offset_ff),
      .in_valid    (req_channel.valid),
      .in_secs     (req_channel.seconds_since_1900),
      .in_frac     (req_channel.second_fraction),
      .in_ready    (req_channel.ready),
      .out_item    (day_item),
      .out_ready   (time_ready)
   );

   ttc_time_split u_time_split (
      .clock     (clock),
      .reset     (reset),
      .in_item   (day_item),
      .in_ready  (time_ready),
      .out_item  (time_item),
      .out_ready (date_ready)
   );

   ttc_date_build u_date_build (
      .clock     (clock),
      .reset     (reset),
      .in_item   (time_item),
      .in_ready  (date_ready),
      .out_item  (result_item),
      .out_ready (rsp_channel.ready)
   );

   // Result channel.
   assign rsp_channel.valid            = result_item.valid;
   assign rsp_channel.calendar_year    = result_item.calendar_year;
   assign rsp_channel.month_number     = result_item.month_number;
   assign rsp_channel.day_of_month     = result_item.day_of_month;
   assign rsp_channel.hour_of_day      = result_item.hour_of_day;
   assign rsp_channel.minute_of_hour   = result_item.minute_of_hour;
   assign rsp_channel.second_of_minute = result_item.second_of_minute;
   assign rsp_channel.milliseconds     = result_item.milliseconds;
   assign rsp_channel.weekday          = result_item.weekday;
   assign rsp_channel.ordinal_day      = result_item.ordinal_day;

   // Checks on the results and on the pipeline after reset.
   `TTC_ASSERT_IMPLIES(a_clock_fields, clock, reset, rsp_channel.valid,
      (rsp_channel.month_number >= 4'd1 && rsp_channel.month_number <= 4'd12
       && rsp_channel.day_of_month >= 5'd1 && rsp_channel.hour_of_day <= 5'd23
       && rsp_channel.minute_of_hour <= 6'd59 && rsp_channel.second_of_minute <= 6'd59
       && rsp_channel.milliseconds <= 10'd999),
      "calendar item field out of range")
   `TTC_ASSERT_IMPLIES(a_day_counts, clock, reset, rsp_channel.valid,
      (rsp_channel.weekday <= 3'd6 && rsp_channel.ordinal_day >= 9'd1
       && rsp_channel.ordinal_day <= 9'd366),
      "weekday or ordinal day out of range")
   `TTC_ASSERT_IMPLIES(a_february_days, clock, reset,
      rsp_channel.valid && rsp_channel.month_number == 4'd2,
      rsp_channel.day_of_month <= 5'd29, "February item past day 29")
   `TTC_ASSERT_IMPLIES(a_empty_after_reset, clock, reset, $past(reset),
      !rsp_channel.valid, "result item present straight after reset")

endmodule
`default_nettype wire

// ===== rtl/ttc_day_split.sv =====
// First three pipeline stages: zone offset, March 1900 rebase and split into days, seconds and ms.
`default_nettype none
module ttc_day_split (
   input  logic                clock,
   input  logic                reset,
   input  logic [16:0]         zone_offset,
   input  logic                in_valid,
   input  logic [31:0]         in_secs,
   input  logic [31:0]         in_frac,
   output logic                in_ready,
   output ttc_pkg::ttc_day_type out_item,
   input  logic                out_ready
);

   typedef struct packed {
      logic        valid;
      logic        early;
      logic [31:0] local_secs;
      logic [31:0] secnum;
      logic [31:0] frac;
   } s1_type;

   typedef struct packed {
      logic        valid;
      logic        early;
      logic [24:0] day_num;
      logic [6:0]  sec_low;
      logic [40:0] day_prod;
      logic [24:0] loc_num;
      logic [40:0] loc_prod;
      logic [28:0] ms_num;
      logic [38:0] ms_prod;
   } s2_type;

   s1_type               s1_ff, s1_in;
   s2_type               s2_ff, s2_in;
   ttc_pkg::ttc_day_type s3_ff, s3_in;
   logic                 en1, en2, en3;

   logic [31:0] offset_ext;
   logic [15:0] day_q0, loc_q0;
   logic [10:0] day_r0, loc_r0;
   logic        day_fix, loc_fix, ms_fix;
   logic [9:0]  day_rem;
   logic [9:0]  ms_q0;
   logic [20:0] ms_r0;

   // A stage moves on when it is empty or the stage after it moves on.
   assign en3      = !s3_ff.valid || out_ready;
   assign en2      = !s2_ff.valid || en3;
   assign en1      = !s1_ff.valid || en2;
   assign in_ready = en1;
   assign out_item = s3_ff;

   // Stage one adds the offset and rebases the count to 1 March 1900.
   always_comb begin
      offset_ext       = {{15{zone_offset[16]}}, zone_offset};
      s1_in.valid      = in_valid;
      s1_in.early      = in_secs < ttc_pkg::MARCH_1900;
      s1_in.local_secs = in_secs + offset_ext;
      s1_in.secnum     = in_secs + offset_ext
                       + (s1_in.early ? ttc_pkg::EARLY_BIAS : ttc_pkg::LATE_BIAS);
      s1_in.frac       = in_frac;
   end

   // Stage two forms the reciprocal products for the day and millisecond quotients.
   always_comb begin
      s2_in.valid    = s1_ff.valid;
      s2_in.early    = s1_ff.early;
      s2_in.day_num  = s1_ff.secnum[31:7];
      s2_in.sec_low  = s1_ff.secnum[6:0];
      s2_in.day_prod = 41'(s1_ff.secnum[31:7]) * 41'(ttc_pkg::DAY_RECIP);
      s2_in.loc_num  = s1_ff.local_secs[31:7];
      s2_in.loc_prod = 41'(s1_ff.local_secs[31:7]) * 41'(ttc_pkg::DAY_RECIP);
      s2_in.ms_num   = s1_ff.frac[31:3];
      s2_in.ms_prod  = 39'(s1_ff.frac[31:3]) * 39'(ttc_pkg::MS_RECIP);
   end

   // Stage three corrects each quotient estimate by at most one.
   always_comb begin
      day_q0  = s2_ff.day_prod[40:25];
      day_r0  = 11'(s2_ff.day_num - 25'(day_q0) * 25'(ttc_pkg::DAY_DIV));
      day_fix = day_r0 >= 11'(ttc_pkg::DAY_DIV);
      day_rem = 10'(day_fix ? day_r0 - 11'(ttc_pkg::DAY_DIV) : day_r0);

      loc_q0  = s2_ff.loc_prod[40:25];
      loc_r0  = 11'(s2_ff.loc_num - 25'(loc_q0) * 25'(ttc_pkg::DAY_DIV));
      loc_fix = loc_r0 >= 11'(ttc_pkg::DAY_DIV);

      ms_q0   = s2_ff.ms_prod[38:29];
      ms_r0   = 21'(s2_ff.ms_num - 29'(ms_q0) * 29'(ttc_pkg::MS_DIV));
      ms_fix  = ms_r0 >= 21'(ttc_pkg::MS_DIV);

      s3_in.valid     = s2_ff.valid;
      s3_in.early     = s2_ff.early;
      s3_in.days      = day_q0 + 16'(day_fix);
      s3_in.in_day    = {day_rem, s2_ff.sec_low};
      s3_in.day_local = loc_q0 + 16'(loc_fix);
      s3_in.ms        = ms_q0 + 10'(ms_fix);
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (en1) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (en2) begin
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (en3) begin
         s3_ff <= s3_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ttc_time_split.sv =====
// Stages four to seven: four-year cycle, year in cycle, clock fields and weekday.
`default_nettype none
module ttc_time_split (
   input  logic                 clock,
   input  logic                 reset,
   input  ttc_pkg::ttc_day_type in_item,
   output logic                 in_ready,
   output ttc_pkg::ttc_time_type out_item,
   input  logic                 out_ready
);

   typedef struct packed {
      logic        valid;
      logic        early;
      logic [9:0]  ms;
      logic [15:0] days;
      logic [21:0] cyc_prod;
      logic [16:0] in_day;
      logic [18:0] hour_prod;
      logic [15:0] wk_num;
      logic [29:0] wk_prod;
   } s4_type;

   typedef struct packed {
      logic        valid;
      logic        early;
      logic [9:0]  ms;
      logic [5:0]  cycle;
      logic [10:0] cycle_day;
      logic [4:0]  hour;
      logic [11:0] in_hour;
      logic [2:0]  weekday;
   } s5_type;

   typedef struct packed {
      logic        valid;
      logic        early;
      logic [9:0]  ms;
      logic [5:0]  cycle;
      logic [10:0] cycle_day;
      logic [13:0] yr_prod;
      logic [4:0]  hour;
      logic [11:0] in_hour;
      logic [16:0] min_prod;
      logic [2:0]  weekday;
   } s6_type;

   s4_type                s4_ff, s4_in;
   s5_type                s5_ff, s5_in;
   s6_type                s6_ff, s6_in;
   ttc_pkg::ttc_time_type s7_ff, s7_in;
   logic                  en4, en5, en6, en7;

   logic [5:0]  cyc_q0;
   logic [11:0] cyc_r0;
   logic        cyc_fix;
   logic [12:0] hour_num;
   logic [5:0]  hour_q0;
   logic [8:0]  hour_r0;
   logic        hour_fix;
   logic [7:0]  hour_rem;
   logic [13:0] wk_q0;
   logic [3:0]  wk_r0;
   logic        wk_fix;
   logic [2:0]  yr_q0;
   logic [9:0]  yr_r0;
   logic        yr_fix;
   logic [2:0]  yic_raw;
   logic [8:0]  yr_rem;
   logic [9:0]  min_num;
   logic [6:0]  min_q0;
   logic [4:0]  min_r0;
   logic        min_fix;
   logic [3:0]  min_rem;

   // Elastic stage enables.
   assign en7      = !s7_ff.valid || out_ready;
   assign en6      = !s6_ff.valid || en7;
   assign en5      = !s5_ff.valid || en6;
   assign en4      = !s4_ff.valid || en5;
   assign in_ready = en4;
   assign out_item = s7_ff;

   // Stage four forms the products for the cycle, hour and weekday quotients.
   always_comb begin
      s4_in.valid     = in_item.valid;
      s4_in.early     = in_item.early;
      s4_in.ms        = in_item.ms;
      s4_in.days      = in_item.days;
      s4_in.cyc_prod  = 22'(in_item.days) * 22'(ttc_pkg::CYCLE_RECIP);
      s4_in.in_day    = in_item.in_day;
      s4_in.hour_prod = 19'(in_item.in_day[16:4]) * 19'(ttc_pkg::HOUR_RECIP);
      s4_in.wk_num    = in_item.day_local + 16'(ttc_pkg::FIRST_WEEKDAY);
      s4_in.wk_prod   = 30'(s4_in.wk_num) * 30'(ttc_pkg::WEEK_RECIP);
   end

   // Stage five corrects the cycle, hour and weekday quotients.
   always_comb begin
      cyc_q0   = s4_ff.cyc_prod[21:16];
      cyc_r0   = 12'(s4_ff.days - 16'(cyc_q0) * 16'(ttc_pkg::DAYS_PER_CYCLE));
      cyc_fix  = cyc_r0 >= 12'(ttc_pkg::DAYS_PER_CYCLE);

      hour_num = s4_ff.in_day[16:4];
      hour_q0  = s4_ff.hour_prod[18:13];
      hour_r0  = 9'(hour_num - 13'(hour_q0) * 13'(ttc_pkg::HOUR_DIV));
      hour_fix = hour_r0 >= 9'(ttc_pkg::HOUR_DIV);
      hour_rem = 8'(hour_fix ? hour_r0 - 9'(ttc_pkg::HOUR_DIV) : hour_r0);

      wk_q0    = s4_ff.wk_prod[29:16];
      wk_r0    = 4'(s4_ff.wk_num - 16'(wk_q0) * 16'(ttc_pkg::DAYS_PER_WEEK));
      wk_fix   = wk_r0 >= 4'(ttc_pkg::DAYS_PER_WEEK);

      s5_in.valid     = s4_ff.valid;
      s5_in.early     = s4_ff.early;
      s5_in.ms        = s4_ff.ms;
      s5_in.cycle     = cyc_q0 + 6'(cyc_fix);
      s5_in.cycle_day = 11'(cyc_fix ? cyc_r0 - 12'(ttc_pkg::DAYS_PER_CYCLE) : cyc_r0);
      s5_in.hour      = 5'(hour_q0 + 6'(hour_fix));
      s5_in.in_hour   = {hour_rem, s4_ff.in_day[3:0]};
      s5_in.weekday   = 3'(wk_fix ? wk_r0 - 4'(ttc_pkg::DAYS_PER_WEEK) : wk_r0);
   end

   // Stage six forms the products for the year in cycle and the minute.
   always_comb begin
      s6_in.valid     = s5_ff.valid;
      s6_in.early     = s5_ff.early;
      s6_in.ms        = s5_ff.ms;
      s6_in.cycle     = s5_ff.cycle;
      s6_in.cycle_day = s5_ff.cycle_day;
      s6_in.yr_prod   = 14'(s5_ff.cycle_day) * 14'(ttc_pkg::YEAR_RECIP);
      s6_in.hour      = s5_ff.hour;
      s6_in.in_hour   = s5_ff.in_hour;
      s6_in.min_prod  = 17'(s5_ff.in_hour[11:2]) * 17'(ttc_pkg::MIN_RECIP);
      s6_in.weekday   = s5_ff.weekday;
   end

   // Stage seven settles the year in cycle, the day in year, minute and second.
   // The last day of a cycle falls in its fourth year as a day 366.
   always_comb begin
      yr_q0   = s6_ff.yr_prod[13:11];
      yr_r0   = 10'(s6_ff.cycle_day - 11'(yr_q0) * 11'(ttc_pkg::DAYS_PER_YEAR));
      yr_fix  = yr_r0 >= 10'(ttc_pkg::DAYS_PER_YEAR);
      yic_raw = yr_q0 + 3'(yr_fix);
      yr_rem  = 9'(yr_fix ? yr_r0 - 10'(ttc_pkg::DAYS_PER_YEAR) : yr_r0);

      min_num = s6_ff.in_hour[11:2];
      min_q0  = s6_ff.min_prod[16:10];
      min_r0  = 5'(min_num - 10'(min_q0) * 10'(ttc_pkg::MIN_DIV));
      min_fix = min_r0 >= 5'(ttc_pkg::MIN_DIV);
      min_rem = 4'(min_fix ? min_r0 - 5'(ttc_pkg::MIN_DIV) : min_r0);

      s7_in.valid = s6_ff.valid;
      s7_in.early = s6_ff.early;
      s7_in.cycle = s6_ff.cycle;
      if (yic_raw == 3'(ttc_pkg::YEARS_PER_CYCLE)) begin
         s7_in.cycle_year = 2'(ttc_pkg::YEARS_PER_CYCLE - 1);
         s7_in.year_day   = yr_rem + 9'(ttc_pkg::DAYS_PER_YEAR);
      end else begin
         s7_in.cycle_year = yic_raw[1:0];
         s7_in.year_day   = yr_rem;
      end
      s7_in.hour    = s6_ff.hour;
      s7_in.minute  = 6'(min_q0 + 7'(min_fix));
      s7_in.second  = {min_rem, s6_ff.in_hour[1:0]};
      s7_in.ms      = s6_ff.ms;
      s7_in.weekday = s6_ff.weekday;
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
      end else if (en4) begin
         s4_ff <= s4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ff.valid <= 1'b0;
      end else if (en5) begin
         s5_ff <= s5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ff.valid <= 1'b0;
      end else if (en6) begin
         s6_ff <= s6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ff.valid <= 1'b0;
      end else if (en7) begin
         s7_ff <= s7_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ttc_date_build.sv =====
// Stages eight and nine: month lookup, calendar year, day of month and ordinal day.
`default_nettype none
module ttc_date_build (
   input  logic                   clock,
   input  logic                   reset,
   input  ttc_pkg::ttc_time_type  in_item,
   output logic                   in_ready,
   output ttc_pkg::ttc_result_type out_item,
   input  logic                   out_ready
);

   typedef struct packed {
      logic        valid;
      logic [10:0] year_base;
      logic [3:0]  month_index;
      logic [8:0]  year_day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  ms;
      logic [2:0]  weekday;
   } s8_type;

   s8_type                  s8_ff, s8_in;
   ttc_pkg::ttc_result_type s9_ff, s9_in;
   logic                    en8, en9;
   logic                    after_feb;
   logic                    leap;

   // Elastic stage enables; stage nine is the output register.
   assign en9      = !s9_ff.valid || out_ready;
   assign en8      = !s8_ff.valid || en9;
   assign in_ready = en8;
   assign out_item = s9_ff;

   // Stage eight finds the March-based month and the year of the cycle.
   always_comb begin
      s8_in.valid       = in_item.valid;
      s8_in.year_base   = 11'(ttc_pkg::BASE_YEAR) + 11'({in_item.cycle, 2'b00})
                        + 11'(in_item.cycle_year) - 11'(in_item.early);
      s8_in.month_index = ttc_pkg::march_month(in_item.year_day);
      s8_in.year_day    = in_item.year_day;
      s8_in.hour        = in_item.hour;
      s8_in.minute      = in_item.minute;
      s8_in.second      = in_item.second;
      s8_in.ms          = in_item.ms;
      s8_in.weekday     = in_item.weekday;
   end

   // Stage nine builds the result. The year always lies between 1899 and 2040, so
   // the only multiple of four that is not a leap year is 1900.
   always_comb begin
      after_feb = s8_ff.month_index >= 4'(ttc_pkg::JANUARY_INDEX);
      leap      = (s8_ff.year_base[1:0] == 2'b00)
               && (s8_ff.year_base != 11'(ttc_pkg::BASE_YEAR));

      s9_in.valid         = s8_ff.valid;
      s9_in.calendar_year = s8_ff.year_base + 11'(after_feb);
      if (after_feb) begin
         s9_in.month_number = s8_ff.month_index - 4'(ttc_pkg::JANUARY_INDEX - 1);
         s9_in.ordinal_day  = s8_ff.year_day - 9'(ttc_pkg::JANUARY_START - 1);
      end else begin
         s9_in.month_number = s8_ff.month_index + 4'(ttc_pkg::MARCH_NUMBER);
         s9_in.ordinal_day  = s8_ff.year_day + 9'(ttc_pkg::MARCH_ORDINAL) + 9'(leap);
      end
      s9_in.day_of_month     = 5'(s8_ff.year_day
                             - ttc_pkg::MARCH_MONTH_START[s8_ff.month_index]) + 5'd1;
      s9_in.hour_of_day      = s8_ff.hour;
      s9_in.minute_of_hour   = s8_ff.minute;
      s9_in.second_of_minute = s8_ff.second;
      s9_in.milliseconds     = s8_ff.ms;
      s9_in.weekday          = s8_ff.weekday;
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ff.valid <= 1'b0;
      end else if (en8) begin
         s8_ff <= s8_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_ff.valid <= 1'b0;
      end else if (en9) begin
         s9_ff <= s9_in;
      end
   end

endmodule
`default_nettype wire
